/* design/assert_macros.svh */
// Assertion macros used by the checker file pkmad_checker.sv.
// Stands alone; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, ignored while reset is high.
`define PKMAD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Check a property on every rising edge, reset included.
`define PKMAD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/pkmad_pkg.sv */
// Shared types and constants of the per-key moving average deviation unit.
// No dependencies; imported by every module of the block.
package pkmad_pkg;

   localparam int DEFAULT_WINDOW      = 50;
   localparam int DEFAULT_NUM_SYMBOLS = 256;

   localparam int SYMBOL_W     = 8;
   localparam int PRICE_W      = 32;
   localparam int SAMPLE_W     = 6;
   localparam int TOTAL_OUT_W  = 38;
   localparam int THRESHOLD_W  = 16;
   localparam int REQ_DATA_W   = 40;
   localparam int RSP_DATA_W   = 88;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [SAMPLE_W-1:0]    MIN_SAMPLES_RESET = 6'd10;
   localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET   = 16'd6554;

   // Register index, taken from paddr[2]
   localparam logic REG_MIN_SAMPLES = 1'b0;
   localparam logic REG_THRESHOLD   = 1'b1;

   // Item travelling down the judge stages
   typedef struct packed {
      logic                valid;
      logic                in_range;
      logic [SYMBOL_W-1:0] symbol;
      logic [PRICE_W-1:0]  price;
   } pkmad_item_type;

   // Finished result word
   typedef struct packed {
      logic                   valid;
      logic [SYMBOL_W-1:0]    symbol;
      logic [PRICE_W-1:0]     price;
      logic                   primed;
      logic                   alert;
      logic [SAMPLE_W-1:0]    sample_count;
      logic [TOTAL_OUT_W-1:0] window_total;
   } pkmad_rsp_type;

endpackage

/* design/per_key_moving_average_deviation_unit.sv */
// Per-key moving average deviation unit: top level, pipeline control, CSRs.
// Each word passes stage 1, stage 2, judge stages s3 and s4, then the output register.
// Throughput: one word per cycle while the skid entry is empty; the state memory read-modify-write forwards repeats.
// Output register plus one skid entry absorb rsp_tready stalls.
// Reset: a clearing pass over all NUM_SYMBOLS state entries holds req_tready low; CSRs take defaults.
// Uses pkmad_pkg, pkmad_meta_ram, pkmad_ring_ram and pkmad_judge.
module per_key_moving_average_deviation_unit import pkmad_pkg::*; #(
   parameter int WINDOW      = DEFAULT_WINDOW,
   parameter int NUM_SYMBOLS = DEFAULT_NUM_SYMBOLS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [7:0] symbol_index, [39:8] price
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [7:0] symbol_out, [39:8] price_out, [40] primed, [41] alert,
   // [47:42] sample_count, [85:48] window_total, [87:86] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int CNT_W   = $clog2(WINDOW + 1);
   localparam int SLOT_W  = $clog2(WINDOW);
   localparam int TOTAL_W = PRICE_W + CNT_W;
   localparam int META_W  = CNT_W + SLOT_W + TOTAL_W;
   localparam int SYM_W   = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
   localparam int PDEPTH  = NUM_SYMBOLS * WINDOW;
   localparam int PADDR_W = $clog2(PDEPTH);

   // configuration
   logic [SAMPLE_W-1:0]    min_samples_ff;
   logic [THRESHOLD_W-1:0] threshold_ff;
   logic                   csr_write;

   // clearing pass
   logic             clearing_ff;
   logic [SYM_W-1:0] clear_idx_ff;

   // handshake
   logic                advance;
   logic                accept;
   logic [SYMBOL_W-1:0] req_symbol;
   logic [PRICE_W-1:0]  req_price;
   logic                req_in_range;

   // stage 1
   logic                s1_v_ff, s1_inr_ff;
   logic [SYMBOL_W-1:0] s1_sym_ff;
   logic [PRICE_W-1:0]  s1_price_ff;
   logic [SYM_W-1:0]    s1_idx_ff;
   logic [META_W-1:0]   meta_rd_ff;
   logic [CNT_W-1:0]    s1_cnt, s1_new_cnt;
   logic [SLOT_W-1:0]   s1_old, s1_new_old, s1_slot;
   logic [TOTAL_W-1:0]  s1_total;
   logic                s1_full;
   logic [PADDR_W-1:0]  ring_addr;
   logic                ring_en;
   logic [PRICE_W-1:0]  evicted_ff;

   // stage 2
   logic                s2_v_ff, s2_inr_ff, s2_full_ff;
   logic [SYMBOL_W-1:0] s2_sym_ff;
   logic [PRICE_W-1:0]  s2_price_ff;
   logic [SYM_W-1:0]    s2_idx_ff;
   logic [CNT_W-1:0]    s2_cnt_ff;
   logic [SLOT_W-1:0]   s2_old_ff;
   logic [TOTAL_W-1:0]  s2_total_old_ff, s2_total;
   logic                s2_write;

   // last meta write, for the word whose read raced it
   logic              lw_v_ff;
   logic [SYM_W-1:0]  lw_idx_ff;
   logic [META_W-1:0] lw_meta_ff;

   // meta write port
   logic              meta_wr_en;
   logic [SYM_W-1:0]  meta_wr_addr;
   logic [META_W-1:0] meta_wr_data;
   logic [META_W-1:0] s1_meta;

   // judge and output
   pkmad_item_type judge_item;
   pkmad_rsp_type  judge_rsp;
   pkmad_rsp_type  out_ff, skid_ff;

   //------------------------------------------------------------------ CSR
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_samples_ff <= MIN_SAMPLES_RESET;
         threshold_ff   <= THRESHOLD_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            REG_MIN_SAMPLES: min_samples_ff <= csr_pwdata[SAMPLE_W-1:0];
            REG_THRESHOLD:   threshold_ff   <= csr_pwdata[THRESHOLD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_MIN_SAMPLES: csr_prdata = CSR_DATA_W'(min_samples_ff);
         REG_THRESHOLD:   csr_prdata = CSR_DATA_W'(threshold_ff);
         default:         csr_prdata = '0;
      endcase
   end

   //------------------------------------------------------------ clearing
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clear_idx_ff <= '0;
      end else if (clearing_ff) begin
         if (clear_idx_ff == SYM_W'(NUM_SYMBOLS - 1)) begin
            clearing_ff <= 1'b0;
         end else begin
            clear_idx_ff <= clear_idx_ff + SYM_W'(1);
         end
      end
   end

   //------------------------------------------------------------ handshake
   assign advance      = !skid_ff.valid;
   assign req_tready   = advance && !clearing_ff;
   assign accept       = req_tvalid && req_tready;
   assign req_symbol   = req_tdata[SYMBOL_W-1:0];
   assign req_price    = req_tdata[SYMBOL_W +: PRICE_W];
   assign req_in_range = ({24'd0, req_symbol} < 32'(NUM_SYMBOLS));

   //------------------------------------------------------------ stage 1
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (advance) begin
         s1_v_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_inr_ff   <= req_in_range;
         s1_sym_ff   <= req_symbol;
         s1_price_ff <= req_price;
         s1_idx_ff   <= req_in_range ? SYM_W'(req_symbol) : '0;
      end
   end

   pkmad_meta_ram #(
      .DEPTH  (NUM_SYMBOLS),
      .WIDTH  (META_W),
      .ADDR_W (SYM_W)
   ) u_meta_ram (
      .clock      (clock),
      .wr_en      (meta_wr_en),
      .wr_addr    (meta_wr_addr),
      .wr_data    (meta_wr_data),
      .rd_en      (advance),
      .rd_addr    (req_in_range ? SYM_W'(req_symbol) : '0),
      .rd_data_ff (meta_rd_ff)
   );

   // Take the newest state of the symbol: the word in stage 2, then the last write
   always_comb begin
      if (s2_v_ff && s2_inr_ff && (s2_idx_ff == s1_idx_ff)) begin
         s1_meta = {s2_cnt_ff, s2_old_ff, s2_total};
      end else if (lw_v_ff && (lw_idx_ff == s1_idx_ff)) begin
         s1_meta = lw_meta_ff;
      end else begin
         s1_meta = meta_rd_ff;
      end
   end

   always_comb begin
      {s1_cnt, s1_old, s1_total} = s1_meta;
      s1_full    = (s1_cnt == CNT_W'(WINDOW));
      s1_slot    = s1_full ? s1_old : SLOT_W'(s1_cnt);
      s1_new_cnt = s1_full ? s1_cnt : s1_cnt + CNT_W'(1);
      if (!s1_full) begin
         s1_new_old = s1_old;
      end else if (s1_old == SLOT_W'(WINDOW - 1)) begin
         s1_new_old = '0;
      end else begin
         s1_new_old = s1_old + SLOT_W'(1);
      end
      ring_addr = PADDR_W'(s1_idx_ff) * PADDR_W'(WINDOW) + PADDR_W'(s1_slot);
      ring_en   = advance && s1_v_ff && s1_inr_ff;
   end

   pkmad_ring_ram #(
      .DEPTH  (PDEPTH),
      .ADDR_W (PADDR_W)
   ) u_ring_ram (
      .clock      (clock),
      .en         (ring_en),
      .addr       (ring_addr),
      .wr_data    (s1_price_ff),
      .rd_data_ff (evicted_ff)
   );

   //------------------------------------------------------------ stage 2
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (advance) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_inr_ff       <= s1_inr_ff;
         s2_sym_ff       <= s1_sym_ff;
         s2_price_ff     <= s1_price_ff;
         s2_idx_ff       <= s1_idx_ff;
         s2_full_ff      <= s1_full;
         s2_cnt_ff       <= s1_new_cnt;
         s2_old_ff       <= s1_new_old;
         s2_total_old_ff <= s1_total;
      end
   end

   assign s2_total = s2_total_old_ff - (s2_full_ff ? TOTAL_W'(evicted_ff) : '0)
                     + TOTAL_W'(s2_price_ff);
   assign s2_write = advance && s2_v_ff && s2_inr_ff;

   always_comb begin
      meta_wr_en   = clearing_ff || s2_write;
      meta_wr_addr = clearing_ff ? clear_idx_ff : s2_idx_ff;
      meta_wr_data = clearing_ff ? '0 : {s2_cnt_ff, s2_old_ff, s2_total};
   end

   always_ff @(posedge clock) begin
      if (reset || clearing_ff) begin
         lw_v_ff <= 1'b0;
      end else if (s2_write) begin
         lw_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_write) begin
         lw_idx_ff  <= s2_idx_ff;
         lw_meta_ff <= {s2_cnt_ff, s2_old_ff, s2_total};
      end
   end

   //------------------------------------------------------------ judge
   always_comb begin
      judge_item.valid    = s2_v_ff;
      judge_item.in_range = s2_inr_ff;
      judge_item.symbol   = s2_sym_ff;
      judge_item.price    = s2_price_ff;
   end

   pkmad_judge #(
      .CNT_W   (CNT_W),
      .TOTAL_W (TOTAL_W)
   ) u_judge (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .item_in     (judge_item),
      .count_in    (s2_inr_ff ? s2_cnt_ff : '0),
      .total_in    (s2_inr_ff ? s2_total : '0),
      .min_samples (min_samples_ff),
      .threshold   (threshold_ff),
      .result      (judge_rsp)
   );

   //------------------------------------------------------------ output
   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid  <= 1'b0;
         skid_ff.valid <= 1'b0;
      end else if (skid_ff.valid) begin
         // drain the skid entry once the current word leaves
         if (rsp_tready) begin
            out_ff        <= skid_ff;
            skid_ff.valid <= 1'b0;
         end
      end else if (out_ff.valid && !rsp_tready) begin
         if (judge_rsp.valid) begin
            skid_ff <= judge_rsp;
         end
      end else begin
         out_ff <= judge_rsp;
      end
   end

   assign rsp_tvalid = out_ff.valid;
   assign rsp_tdata  = {2'b00, out_ff.window_total, out_ff.sample_count, out_ff.alert,
                        out_ff.primed, out_ff.price, out_ff.symbol};

endmodule

/* design/pkmad_meta_ram.sv */
// Per-symbol state memory: fill count, oldest slot and running total.
// One write port, one read port with registered read data; uses pkmad_pkg.
module pkmad_meta_ram import pkmad_pkg::*; #(
   parameter int DEPTH  = DEFAULT_NUM_SYMBOLS,
   parameter int WIDTH  = 52,
   parameter int ADDR_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

/* design/pkmad_ring_ram.sv */
// Price ring memory, all symbols' windows back to back.
// Single port, read-first: the evicted price comes out as the new one goes in.
module pkmad_ring_ram import pkmad_pkg::*; #(
   parameter int DEPTH  = DEFAULT_NUM_SYMBOLS * DEFAULT_WINDOW,
   parameter int ADDR_W = 14
) (
   input  logic               clock,
   input  logic               en,
   input  logic [ADDR_W-1:0]  addr,
   input  logic [PRICE_W-1:0] wr_data,
   output logic [PRICE_W-1:0] rd_data_ff
);

   logic [PRICE_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         rd_data_ff <= mem[addr];
         mem[addr]  <= wr_data;
      end
   end

endmodule

/* design/pkmad_judge.sv */
// Deviation judge: primed compare, products, then the threshold compare.
// Two pipeline stages moving on advance; uses pkmad_pkg.
module pkmad_judge import pkmad_pkg::*; #(
   parameter int CNT_W   = 6,
   parameter int TOTAL_W = 38
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  pkmad_item_type         item_in,
   input  logic [CNT_W-1:0]       count_in,
   input  logic [TOTAL_W-1:0]     total_in,
   input  logic [SAMPLE_W-1:0]    min_samples,
   input  logic [THRESHOLD_W-1:0] threshold,
   output pkmad_rsp_type          result
);

   localparam int THR_W = TOTAL_W + THRESHOLD_W;
   localparam int CMP_W = (CNT_W > SAMPLE_W) ? CNT_W : SAMPLE_W;

   pkmad_item_type     s3_item_ff, s4_item_ff;
   logic [CNT_W-1:0]   s3_cnt_ff, s4_cnt_ff;
   logic [TOTAL_W-1:0] s3_total_ff, s4_total_ff;
   logic               s3_primed_ff, s4_primed_ff;
   logic [TOTAL_W-1:0] s4_pc_ff;
   logic [THR_W-1:0]   s4_thr_ff;
   logic               primed_in;
   logic [TOTAL_W-1:0] diff;
   logic               alert;

   assign primed_in = item_in.in_range && (CMP_W'(count_in) >= CMP_W'(min_samples));

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_item_ff.valid <= 1'b0;
         s4_item_ff.valid <= 1'b0;
      end else if (advance) begin
         s3_item_ff.valid <= item_in.valid;
         s4_item_ff.valid <= s3_item_ff.valid;
      end

      if (advance) begin
         s3_item_ff.in_range <= item_in.in_range;
         s3_item_ff.symbol   <= item_in.symbol;
         s3_item_ff.price    <= item_in.price;
         s3_cnt_ff           <= count_in;
         s3_total_ff         <= total_in;
         s3_primed_ff        <= primed_in;

         s4_item_ff.in_range <= s3_item_ff.in_range;
         s4_item_ff.symbol   <= s3_item_ff.symbol;
         s4_item_ff.price    <= s3_item_ff.price;
         s4_cnt_ff           <= s3_cnt_ff;
         s4_total_ff         <= s3_total_ff;
         s4_primed_ff        <= s3_primed_ff;
         s4_pc_ff            <= TOTAL_W'(s3_item_ff.price) * TOTAL_W'(s3_cnt_ff);
         s4_thr_ff           <= THR_W'(threshold) * THR_W'(s3_total_ff);
      end
   end

   // |price*count - sum| * 2^16 > threshold * sum
   always_comb begin
      diff  = (s4_pc_ff >= s4_total_ff) ? (s4_pc_ff - s4_total_ff)
                                        : (s4_total_ff - s4_pc_ff);
      alert = s4_primed_ff && ({diff, {THRESHOLD_W{1'b0}}} > s4_thr_ff);
   end

   always_comb begin
      result.valid        = s4_item_ff.valid;
      result.symbol       = s4_item_ff.symbol;
      result.price        = s4_item_ff.price;
      result.primed       = s4_primed_ff;
      result.alert        = alert;
      result.sample_count = SAMPLE_W'(s4_cnt_ff);
      result.window_total = TOTAL_OUT_W'(s4_total_ff);
   end

endmodule

/* design/pkmad_checker.sv */
// Port-level checker of the per-key moving average deviation unit, bound to the top.
// Uses pkmad_pkg and the macros in assert_macros.svh.
`include "assert_macros.svh"

module pkmad_checker import pkmad_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic bad_alert;
   logic rsp_stall;

   // [40] primed, [41] alert
   assign bad_alert = rsp_tdata[41] && !rsp_tdata[40];
   assign rsp_stall = rsp_tvalid && !rsp_tready;

   // the clearing pass after reset keeps the input closed and the output empty
   `PKMAD_ASSERT_ALWAYS(a_ready_low, clock, reset |=> !req_tready, "ready after reset")
   `PKMAD_ASSERT_ALWAYS(a_no_rsp_after_reset, clock, reset |=> !rsp_tvalid, "result after reset")
   // an alert word is always a primed word
   `PKMAD_ASSERT(a_alert_primed, clock, reset, rsp_tvalid |-> !bad_alert, "alert unprimed")
   `PKMAD_ASSERT(a_rsp_hold_valid, clock, reset, rsp_stall |=> rsp_tvalid, "stalled word lost")
   `PKMAD_ASSERT(a_rsp_hold_data, clock, reset, rsp_stall |=> $stable(rsp_tdata), "word changed")

endmodule

bind per_key_moving_average_deviation_unit pkmad_checker u_pkmad_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
